[hdl/sm3_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and functions for the SM3 hash engine.
// No dependencies.
package sm3_pkg;

  // One 32-bit word on its way from the padding front end to the compressor
  typedef struct packed {
    logic        fin;
    logic [31:0] word;
  } qword_t;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [31:0] PAD_WORD = 32'h80000000;

  localparam logic [31:0] IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  // Rotation by a constant amount
  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    perm0 = x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    perm1 = x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  // Round constant, already rotated by the round number (mod 32)
  function automatic logic [31:0] round_const(input logic [5:0] j);
    logic [31:0] base;
    logic [5:0]  sh;
    base = (j < 6'd16) ? T_LOW : T_HIGH;
    sh = {1'b0, j[4:0]};
    round_const = (sh == 6'd0) ? base : ((base << sh) | (base >> (6'd32 - sh)));
  endfunction

endpackage

[hdl/sm3_front.sv]
`timescale 1ns / 1ps
// Front end: takes message words, counts the bit length and inserts padding.
// Depends on sm3_pkg.
module sm3_front import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] message_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        ready,
  input  logic        q_full,
  output logic        q_wr,
  output qword_t      q_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P80  = 3'd1;
  localparam logic [2:0] S_ZERO = 3'd2;
  localparam logic [2:0] S_LO   = 3'd3;

  logic [2:0]  state, state_next;
  logic [3:0]  wcount, wcount_next;
  logic [63:0] bitlen, bitlen_next;
  logic [2:0]  cnt;
  logic [31:0] last_val;
  logic        take;

  assign ready = (state == S_IDLE) && !q_full;
  assign take  = push && ready;
  assign cnt   = (byte_count > 3'd4) ? 3'd4 : byte_count;

  // Mask the invalid bytes and place the 0x80 marker
  always_comb begin
    case (cnt)
      3'd0:    last_val = 32'h80000000;
      3'd1:    last_val = {message_word[31:24], 24'h800000};
      3'd2:    last_val = {message_word[31:16], 16'h8000};
      3'd3:    last_val = {message_word[31:8], 8'h80};
      default: last_val = message_word;
    endcase
  end

  // Sequence the words into the queue
  always_comb begin
    state_next  = state;
    wcount_next = wcount;
    bitlen_next = bitlen;
    q_wr        = 1'b0;
    q_data      = '{fin: 1'b0, word: 32'd0};
    case (state)
      S_IDLE: begin
        if (take) begin
          q_wr        = 1'b1;
          wcount_next = wcount + 4'd1;
          if (!last_word) begin
            q_data.word = message_word;
            bitlen_next = bitlen + 64'd32;
          end else begin
            q_data.word = last_val;
            bitlen_next = bitlen + {58'd0, cnt, 3'd0};
            state_next  = (cnt == 3'd4) ? S_P80 : S_ZERO;
          end
        end
      end
      S_P80: begin
        if (!q_full) begin
          q_wr        = 1'b1;
          q_data.word = PAD_WORD;
          wcount_next = wcount + 4'd1;
          state_next  = S_ZERO;
        end
      end
      S_ZERO: begin
        if (!q_full) begin
          q_wr        = 1'b1;
          wcount_next = wcount + 4'd1;
          if (wcount == 4'd14) begin
            q_data.word = bitlen[63:32];
            state_next  = S_LO;
          end
        end
      end
      S_LO: begin
        if (!q_full) begin
          q_wr        = 1'b1;
          q_data.fin  = 1'b1;
          q_data.word = bitlen[31:0];
          wcount_next = 4'd0;
          bitlen_next = 64'd0;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wcount <= 4'd0;
      bitlen <= 64'd0;
    end else begin
      state  <= state_next;
      wcount <= wcount_next;
      bitlen <= bitlen_next;
    end
  end

endmodule

[hdl/sm3_queue.sv]
`timescale 1ns / 1ps
// Four-entry word queue between the padding front end and the compressor.
// Depends on sm3_pkg.
module sm3_queue import sm3_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  qword_t wdata,
  output logic   full,
  input  logic   rd,
  output qword_t rdata,
  output logic   empty
);

  qword_t     mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       do_wr, do_rd;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (do_wr) wptr <= wptr + 2'd1;
      if (do_rd) rptr <= rptr + 2'd1;
      count <= count + {2'd0, do_wr} - {2'd0, do_rd};
    end
  end

endmodule

[hdl/sm3_back.sv]
`timescale 1ns / 1ps
// Back end: collects 16-word blocks, runs 64 compression rounds, emits digest.
// Depends on sm3_pkg.
module sm3_back import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  qword_t      q_data,
  input  logic        q_empty,
  output logic        q_rd,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic        digest_last
);

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_COMP    = 2'd1;
  localparam logic [1:0] S_EMIT    = 2'd2;

  logic [1:0]  state;
  logic [3:0]  wcnt;
  logic [5:0]  round;
  logic [2:0]  oidx;
  logic        fin_blk;
  logic [31:0] w [16];
  logic [31:0] cv [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] wnew, ss1, ss2, tt1, tt2, ff, gg, a12;
  logic        take;

  assign q_rd        = (state == S_COLLECT);
  assign take        = q_rd && !q_empty;
  assign empty       = (state != S_EMIT);
  assign digest_word = cv[oidx];
  assign digest_last = (oidx == 3'd7);

  // Message expansion and one compression round
  always_comb begin
    wnew = perm1(w[0] ^ w[7] ^ rotl(w[13], 15)) ^ rotl(w[3], 7) ^ w[10];
    a12  = rotl(a, 12);
    ss1  = rotl(a12 + e + round_const(round), 7);
    ss2  = ss1 ^ a12;
    if (round < 6'd16) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
    tt1 = ff + d + ss2 + (w[0] ^ w[4]);
    tt2 = gg + h + ss1 + w[0];
  end

  // Word window: shift in during collection and during rounds
  always_ff @(posedge clk) begin
    if (take || state == S_COMP) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= (state == S_COMP) ? wnew : q_data.word;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (take && wcnt == 4'd15) begin
      {a, b, c, d, e, f, g, h} <= {cv[0], cv[1], cv[2], cv[3], cv[4], cv[5], cv[6], cv[7]};
    end else if (state == S_COMP) begin
      d <= c;
      c <= rotl(b, 9);
      b <= a;
      a <= tt1;
      h <= g;
      g <= rotl(f, 19);
      f <= e;
      e <= perm0(tt2);
    end
  end

  // Control, chaining value and digest output
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_COLLECT;
      wcnt    <= 4'd0;
      round   <= 6'd0;
      oidx    <= 3'd0;
      fin_blk <= 1'b0;
      for (int i = 0; i < 8; i++) cv[i] <= IV[i];
    end else begin
      case (state)
        S_COLLECT: begin
          if (take) begin
            wcnt <= wcnt + 4'd1;
            if (wcnt == 4'd15) begin
              fin_blk <= q_data.fin;
              round   <= 6'd0;
              state   <= S_COMP;
            end
          end
        end
        S_COMP: begin
          round <= round + 6'd1;
          if (round == 6'd63) begin
            cv[0] <= cv[0] ^ tt1;
            cv[1] <= cv[1] ^ a;
            cv[2] <= cv[2] ^ rotl(b, 9);
            cv[3] <= cv[3] ^ c;
            cv[4] <= cv[4] ^ perm0(tt2);
            cv[5] <= cv[5] ^ e;
            cv[6] <= cv[6] ^ rotl(f, 19);
            cv[7] <= cv[7] ^ g;
            oidx  <= 3'd0;
            state <= fin_blk ? S_EMIT : S_COLLECT;
          end
        end
        S_EMIT: begin
          if (pop) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) cv[i] <= IV[i];
              state <= S_COLLECT;
            end
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  a_round_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_COMP) |-> (round == 6'd0))
    else $error("round counter moved outside compression");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && pop && oidx == 3'd7) |=> (state == S_COLLECT && empty))
    else $error("digest did not close after eighth word");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    (take && wcnt == 4'd15) |=> (state == S_COMP && round == 6'd0))
    else $error("full block did not start compression");

endmodule

[hdl/sm3_hash_engine.sv]
`timescale 1ns / 1ps
// SM3 hash engine, top level: front end, word queue and compressor.
// Depends on sm3_pkg, sm3_front, sm3_queue, sm3_back.
//
// Usage: write message words through push/full, big-endian, and mark the
// final word with last_word and its count of valid bytes (0 to 4). The
// final word makes the front insert padding and the 64-bit bit length,
// one word a cycle while the queue has room. Words pass a four-entry
// queue to the compressor, which collects 16 words (one a cycle while the
// queue holds words) and then runs 64 rounds at one round a cycle, taking
// no new words until the block is done. The digest waits for an extra
// block when the padding spills into one, and for any earlier block that
// is still being compressed. After the last block, the eight digest words
// appear on the result side (empty low), first word first, digest_last on
// the eighth. A stalled receiver (pop low) holds the digest; the front
// keeps taking words until the queue fills. After the eighth transfer the
// chaining value returns to the IV. Reset clears all control state and
// loads the IV.
module sm3_hash_engine import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] message_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic        digest_last
);

  qword_t wq_data, rq_data;
  logic   wq_wr, q_full, q_rd, q_empty, ready;

  assign full = !ready;

  sm3_front u_front (
    .clk(clk), .rst(rst), .push(push), .message_word(message_word),
    .byte_count(byte_count), .last_word(last_word), .ready(ready),
    .q_full(q_full), .q_wr(wq_wr), .q_data(wq_data)
  );

  sm3_queue u_queue (
    .clk(clk), .rst(rst), .wr(wq_wr), .wdata(wq_data), .full(q_full),
    .rd(q_rd), .rdata(rq_data), .empty(q_empty)
  );

  sm3_back u_back (
    .clk(clk), .rst(rst), .q_data(rq_data), .q_empty(q_empty), .q_rd(q_rd),
    .empty(empty), .pop(pop), .digest_word(digest_word),
    .digest_last(digest_last)
  );

endmodule
